>>> hw/rtl/srsw_pkg.sv
// Shared types, codes and helpers for the selective-repeat sender window.
`default_nettype none

package srsw_pkg;

  localparam int WINDOW = 32;

  typedef enum logic [1:0] {
    FUNC_FILL    = 2'd0,
    FUNC_ACK     = 2'd1,
    FUNC_TIMEOUT = 2'd2,
    FUNC_NONE    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    KIND_NEW    = 2'd0,
    KIND_RESEND = 2'd1,
    KIND_DONE   = 2'd2,
    KIND_GIVEUP = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_WINDOW_SIZE  = 2'd0,
    REG_TOTAL_CHUNKS = 2'd1,
    REG_MAX_RETRIES  = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    FS_IDLE  = 2'd0,
    FS_EVAL  = 2'd1,
    FS_APPLY = 2'd2
  } front_state_t;

  typedef struct packed {
    logic [5:0]  win_len;
    logic [31:0] chunk_count;
    logic [7:0]  retry_limit;
  } cfg_t;

  // One queued job for the back end: emit seq+i for every set bit i of mask.
  typedef struct packed {
    kind_t       kind;
    logic [31:0] seq;
    logic [31:0] mask;
  } cmd_t;

  typedef struct packed {
    logic       busy;
    logic [5:0] outstanding;
  } front_stat_t;

  // Mask with the low n bits set, n in 0..32.
  function automatic logic [31:0] low_ones(input logic [5:0] n);
    low_ones = ~({32{1'b1}} << n);
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/srsw_front.sv
// Front end: accepts events, updates the window state and queues emit jobs.
`default_nettype none

module srsw_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          func,
  input  wire logic [31:0]         ack_base,
  input  wire logic [31:0]         sack_bits,
  input  wire srsw_pkg::cfg_t      cfg,
  output logic                     cmd_push,
  output srsw_pkg::cmd_t           cmd,
  input  wire logic                cmd_full,
  output srsw_pkg::front_stat_t    stat
);
  import srsw_pkg::*;

  front_state_t state, state_next;

  // latched request
  func_t       item_func;
  logic [31:0] item_abase;
  logic [31:0] item_sack;

  // window state; base and next carry a 33rd bit for total+1
  logic [32:0] window_base, base_next;
  logic [32:0] next_seq, next_seq_next;
  logic [31:0] ack_marks, marks_next;
  logic [7:0]  retry_count, retry_next;
  logic        finished, finished_next;
  logic [5:0]  outstanding, outstanding_next;

  // evaluation stage results
  logic [5:0]  ev_room;
  logic [33:0] ev_rem;
  logic        ev_gt_total, ev_gt_base, ev_gt_next, ev_lt_base, ev_rsh_big;
  logic [5:0]  ev_fwd;
  logic [4:0]  ev_rsh;

  // evaluation combinational terms
  logic [5:0]  eff_w;
  logic [32:0] abase33, fwd33, rsh33;

  // apply combinational terms
  logic [5:0]  n_new, sh, out_after;
  logic [31:0] marks_slid, sack_add;
  logic        need_push, go;

  assign abase33 = {1'b0, item_abase};
  assign fwd33   = abase33 - window_base;
  assign rsh33   = window_base - abase33 - 33'd1;

  always_comb begin
    if (cfg.win_len == 6'd0) begin
      eff_w = 6'd1;
    end else if (cfg.win_len > 6'(WINDOW)) begin
      eff_w = 6'(WINDOW);
    end else begin
      eff_w = cfg.win_len;
    end
  end

  always_ff @(posedge clk) begin
    if (state == FS_IDLE && in_valid) begin
      item_func  <= func_t'(func);
      item_abase <= ack_base;
      item_sack  <= sack_bits;
    end
    if (state == FS_EVAL) begin
      ev_room     <= (eff_w > outstanding) ? eff_w - outstanding : 6'd0;
      ev_rem      <= {2'b00, cfg.chunk_count} + 34'd1 - {1'b0, next_seq};
      ev_gt_total <= item_abase > cfg.chunk_count;
      ev_gt_base  <= abase33 > window_base;
      ev_gt_next  <= abase33 > next_seq;
      ev_lt_base  <= abase33 < window_base;
      ev_fwd      <= fwd33[5:0];
      ev_rsh      <= rsh33[4:0];
      ev_rsh_big  <= |rsh33[32:5];
    end
  end

  always_comb begin
    if (ev_rem[33]) begin
      n_new = 6'd0;
    end else if (|ev_rem[32:6]) begin
      n_new = ev_room;
    end else begin
      n_new = (ev_rem[5:0] < ev_room) ? ev_rem[5:0] : ev_room;
    end
    sh         = ev_gt_next ? outstanding : ev_fwd;
    out_after  = ev_gt_base ? outstanding - sh : outstanding;
    marks_slid = ev_gt_base ? (ack_marks >> sh) : ack_marks;
    // map selective marks onto window offsets of the new base
    if (ev_gt_next) begin
      sack_add = '0;
    end else if (!ev_lt_base) begin
      sack_add = item_sack << 1;
    end else if (ev_rsh_big) begin
      sack_add = '0;
    end else begin
      sack_add = item_sack >> ev_rsh;
    end
  end

  always_comb begin
    need_push        = 1'b0;
    cmd.kind         = KIND_DONE;
    cmd.seq          = '0;
    cmd.mask         = 32'd1;
    base_next        = window_base;
    next_seq_next    = next_seq;
    marks_next       = ack_marks;
    retry_next       = retry_count;
    finished_next    = finished;
    outstanding_next = outstanding;
    if (finished) begin
      need_push = (item_func != FUNC_NONE);
    end else begin
      unique case (item_func)
        FUNC_FILL: begin
          need_push        = (n_new != 6'd0);
          cmd.kind         = KIND_NEW;
          cmd.seq          = next_seq[31:0];
          cmd.mask         = low_ones(n_new);
          marks_next       = ack_marks & ~(low_ones(n_new) << outstanding);
          next_seq_next    = next_seq + {27'd0, n_new};
          outstanding_next = outstanding + n_new;
        end
        FUNC_ACK: begin
          retry_next = '0;
          if (ev_gt_total) begin
            finished_next = 1'b1;
            need_push     = 1'b1;
          end else begin
            if (ev_gt_base) begin
              base_next = ev_gt_next ? next_seq : abase33;
            end
            outstanding_next = out_after;
            marks_next       = marks_slid | (sack_add & low_ones(out_after));
          end
        end
        FUNC_TIMEOUT: begin
          if (retry_count >= cfg.retry_limit) begin
            cmd.kind  = KIND_GIVEUP;
            need_push = 1'b1;
          end else begin
            cmd.kind   = KIND_RESEND;
            cmd.seq    = window_base[31:0];
            cmd.mask   = ~ack_marks & low_ones(outstanding);
            need_push  = |cmd.mask;
            retry_next = retry_count + 8'd1;
          end
        end
        FUNC_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  assign go       = (state == FS_APPLY) && !(need_push && cmd_full);
  assign cmd_push = go && need_push;

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    unique case (state)
      FS_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = FS_EVAL;
        end
      end
      FS_EVAL:  state_next = FS_APPLY;
      FS_APPLY: begin
        if (go) begin
          state_next = FS_IDLE;
        end
      end
      default:  state_next = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_base <= 33'd1;
      next_seq    <= 33'd1;
      ack_marks   <= '0;
      retry_count <= '0;
      finished    <= 1'b0;
      outstanding <= '0;
    end else if (go) begin
      window_base <= base_next;
      next_seq    <= next_seq_next;
      ack_marks   <= marks_next;
      retry_count <= retry_next;
      finished    <= finished_next;
      outstanding <= outstanding_next;
    end
  end

  assign stat.busy        = (state != FS_IDLE);
  assign stat.outstanding = outstanding;

endmodule

`default_nettype wire

>>> hw/rtl/srsw_cmd_fifo.sv
// Two-entry job queue between the front end and the back end.
`default_nettype none

module srsw_cmd_fifo (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire srsw_pkg::cmd_t  wdata,
  output logic                 full,
  input  wire logic            pop,
  output srsw_pkg::cmd_t       rdata,
  output logic                 empty
);
  import srsw_pkg::*;

  cmd_t       mem [2];
  logic       wptr, rptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (push && !full) begin
        wptr <= ~wptr;
      end
      if (pop && !empty) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, (push && !full)} - {1'b0, (pop && !empty)};
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/srsw_back.sv
// Back end: walks a queued job's mask and emits one result per cycle while the output is not stalled.
`default_nettype none

module srsw_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire srsw_pkg::cmd_t  head,
  input  wire logic            head_empty,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic [1:0]           kind,
  output logic [31:0]          seq,
  output logic                 last
);
  import srsw_pkg::*;

  logic        busy;
  kind_t       job_kind;
  logic [31:0] job_seq;
  logic [31:0] job_mask;

  logic [31:0] low_bit, rest;
  logic [4:0]  idx;
  logic        advance;

  assign low_bit = job_mask & (~job_mask + 32'd1);
  assign rest    = job_mask & ~low_bit;

  always_comb begin
    idx = '0;
    for (int i = 31; i >= 0; i--) begin
      if (job_mask[i]) begin
        idx = 5'(i);
      end
    end
  end

  assign pop     = !busy && !head_empty;
  assign advance = busy && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (pop) begin
      job_kind <= head.kind;
      job_seq  <= head.seq;
      job_mask <= head.mask;
    end else if (advance) begin
      job_mask <= rest;
    end
    if (advance) begin
      kind <= job_kind;
      seq  <= job_seq + {27'd0, idx};
      last <= (rest == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
      end else if (advance && rest == '0) begin
        busy <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/selective_repeat_sender_window_unit.sv
// Top level of the selective-repeat ARQ sender window.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------
//  in       | in_valid / in_stall  | func, ack_base, sack_bits
//  out      | out_valid / out_stall| kind, seq, last
//  cfg      | cfg_write            | cfg_index, cfg_data
//
// An input request passes through the front-end states take, evaluate and
// apply; a new request is taken only once the front end is back in idle,
// and the apply step waits while a job must be pushed and the queue is full.
// The back end emits one result per cycle while the output is not stalled;
// it loads a job before its numbers. Reset is synchronous: window base and next number
// go to one, marks and retries clear, the queue and output empty. A stalled
// output holds its result; the two-entry queue lets the front end keep
// taking requests until it fills.
`default_nettype none

module selective_repeat_sender_window_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  // input events
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  func,
  input  wire logic [31:0] ack_base,
  input  wire logic [31:0] sack_bits,
  // results
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       kind,
  output logic [31:0]      seq,
  output logic             last,
  // configuration writes
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import srsw_pkg::*;

  cfg_t        cfg;
  cmd_t        cmd, head;
  logic        cmd_push, cmd_full, head_empty, pop;
  front_stat_t stat;

  // Configuration registers; an index past the list is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.win_len     <= 6'd32;
      cfg.chunk_count <= 32'd1;
      cfg.retry_limit <= 8'd3;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_WINDOW_SIZE:  cfg.win_len     <= cfg_data[5:0];
        REG_TOTAL_CHUNKS: cfg.chunk_count <= cfg_data;
        REG_MAX_RETRIES:  cfg.retry_limit <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // Front end: classify the event and update the window.
  srsw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .ack_base  (ack_base),
    .sack_bits (sack_bits),
    .cfg       (cfg),
    .cmd_push  (cmd_push),
    .cmd       (cmd),
    .cmd_full  (cmd_full),
    .stat      (stat)
  );

  // Job queue decoupling the two halves.
  srsw_cmd_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .wdata (cmd),
    .full  (cmd_full),
    .pop   (pop),
    .rdata (head),
    .empty (head_empty)
  );

  // Back end: expand each job into results, one per cycle while the output is not stalled.
  srsw_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_empty (head_empty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .seq        (seq),
    .last       (last)
  );

  // Status results carry no number and stand alone.
  a_status_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_DONE || kind == KIND_GIVEUP) |-> seq == '0 && last)
    else $error("status result with nonzero seq or without last");

  // The front end never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(cmd_push && cmd_full))
    else $error("job pushed into full queue");

  // Outstanding numbers never exceed the window.
  a_window_bound: assert property (@(posedge clk) disable iff (rst)
    stat.outstanding <= 6'(WINDOW))
    else $error("outstanding count beyond window");

  // A request is taken only while the front end is idle, and a taken request makes it busy.
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> stat.busy)
    else $error("front end did not start on a taken request");

endmodule

`default_nettype wire
